>>> hdl/dotg_pkg.sv
package dotg_pkg;

   localparam int MAX_ROW_PIXELS_DEF = 1024;
   localparam int MAX_ROWS_DEF       = 1024;

   localparam int CFG_W      = 11;
   localparam int CFG_IDX_W  = 1;
   localparam int WORD_W     = 32;
   localparam int ACC_W      = 64;
   localparam int IDX_W      = 5;
   localparam int NUM_WORDS  = 22;
   localparam int NUM_ROW    = 12;
   localparam int NUM_COL    = 6;

   // request kinds (tuser)
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   // configuration register indexes
   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

   // row accumulator slots
   localparam int RA_X   = 0;
   localparam int RA_Y   = 1;
   localparam int RA_XDX = 2;
   localparam int RA_XDY = 3;
   localparam int RA_YDX = 4;
   localparam int RA_YDY = 5;
   localparam int RA_XXX = 6;
   localparam int RA_YXX = 7;
   localparam int RA_YXY = 8;
   localparam int RA_XXY = 9;
   localparam int RA_YYX = 10;
   localparam int RA_YYY = 11;

   // calibration word slots
   localparam int W_AX = 0;
   localparam int W_BX = 1;
   localparam int W_CX = 2;
   localparam int W_DX = 3;
   localparam int W_AY = 4;
   localparam int W_BY = 5;
   localparam int W_CY = 6;
   localparam int W_DY = 7;
   localparam int W_START = 8;

   typedef logic [WORD_W-1:0]       word_type;
   typedef logic [ACC_W-1:0]        acc_type;
   typedef word_type [NUM_WORDS-1:0] words_type;
   typedef acc_type [NUM_ROW-1:0]   row_type;
   typedef acc_type [NUM_COL-1:0]   col_type;

   typedef struct packed {
      logic                load;      // calibration beat accepted
      logic                pixel;     // pixel beat accepted
      logic                first_col; // pixel sits at column 0
      logic                restart;   // rebuild rows from start values
      logic [IDX_W-1:0]    word_index;
      word_type            word_value;
   } ctl_type;

   function automatic acc_type asr(acc_type v, int unsigned n);
      return acc_type'($signed(v) >>> n);
   endfunction

   function automatic acc_type sext(word_type w);
      return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
   endfunction

   function automatic acc_type preshift(word_type w, int unsigned up, int unsigned dn);
      word_type t;
      word_type r;
      t = w << up;
      r = word_type'($signed(t) >>> dn);
      return sext(r);
   endfunction

   function automatic row_type seed(words_type w);
      row_type r;
      r[RA_X] = preshift(w[W_START+0], 13, 4);
      r[RA_Y] = preshift(w[W_START+1], 13, 4);
      for (int i = 0; i < 4; i++) begin
         r[RA_XDX+i] = preshift(w[W_START+2+i], 11, 3);
      end
      for (int i = 0; i < 6; i++) begin
         r[RA_XXX+i] = preshift(w[W_START+6+i], 8, 0);
      end
      return r;
   endfunction

   // one row step; every term reads the old values
   function automatic row_type row_step(row_type r, words_type w);
      row_type n;
      n = r;
      n[RA_XXX] = r[RA_XXX] + sext(w[W_CX]);
      n[RA_XDX] = r[RA_XDX] + asr(r[RA_YXX], 8);
      n[RA_YXX] = r[RA_YXX] + sext(w[W_DX]);
      n[RA_X]   = r[RA_X]   + asr(r[RA_YDX], 6);
      n[RA_YDX] = r[RA_YDX] + asr(r[RA_YYX], 8);
      n[RA_YYX] = r[RA_YYX] + sext(w[W_BX]);
      n[RA_XXY] = r[RA_XXY] + sext(w[W_CY]);
      n[RA_XDY] = r[RA_XDY] + asr(r[RA_YXY], 8);
      n[RA_YXY] = r[RA_YXY] + sext(w[W_DY]);
      n[RA_Y]   = r[RA_Y]   + asr(r[RA_YDY], 6);
      n[RA_YDY] = r[RA_YDY] + asr(r[RA_YYY], 8);
      n[RA_YYY] = r[RA_YYY] + sext(w[W_BY]);
      return n;
   endfunction

   function automatic col_type col_step(col_type c, words_type w);
      col_type n;
      n[0] = c[0] + asr(c[1], 6);
      n[1] = c[1] + asr(c[2], 8);
      n[2] = c[2] + sext(w[W_AX]);
      n[3] = c[3] + asr(c[4], 6);
      n[4] = c[4] + asr(c[5], 8);
      n[5] = c[5] + sext(w[W_AY]);
      return n;
   endfunction

endpackage

>>> hdl/dotg_datapath.sv
module dotg_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  dotg_pkg::ctl_type        ctl,
   output dotg_pkg::acc_type        offset_x,
   output dotg_pkg::acc_type        offset_y
);

   dotg_pkg::words_type words_ff, words_in;
   // row_ff holds the row state already advanced one row (ready for column 0)
   dotg_pkg::row_type   row_ff, row_in;
   dotg_pkg::col_type   col_ff, col_in;
   dotg_pkg::col_type   col_src;

   always_comb begin
      words_in = words_ff;
      if (ctl.load && (int'(ctl.word_index) < dotg_pkg::NUM_WORDS)) begin
         words_in[ctl.word_index] = ctl.word_value;
      end
   end

   always_comb begin
      if (ctl.first_col) begin
         col_src[0] = row_ff[dotg_pkg::RA_X];
         col_src[1] = row_ff[dotg_pkg::RA_XDX];
         col_src[2] = row_ff[dotg_pkg::RA_XXX];
         col_src[3] = row_ff[dotg_pkg::RA_Y];
         col_src[4] = row_ff[dotg_pkg::RA_XDY];
         col_src[5] = row_ff[dotg_pkg::RA_XXY];
      end else begin
         col_src = col_ff;
      end
   end

   assign offset_x = col_src[0];
   assign offset_y = col_src[3];

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (ctl.pixel) begin
         col_in = dotg_pkg::col_step(col_src, words_ff);
         if (ctl.first_col) begin
            row_in = dotg_pkg::row_step(row_ff, words_ff);
         end
      end
      if (ctl.restart) begin
         row_in = dotg_pkg::row_step(dotg_pkg::seed(words_in), words_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         words_ff <= words_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

>>> hdl/depth_offset_table_generator.sv
// Pixel offsets are registered: a beat accepted at edge N shows them on rsp_* after edge N.
// Throughput: one beat per cycle (load or pixel) while the result side takes beats;
// set by a single output register, ready passes through when it drains.
// Reset (synchronous, active high): calibration words and accumulators zero,
// width 640, height 480, position at row 0 column 0, no result pending.
module depth_offset_table_generator #(
   parameter int MAX_ROW_PIXELS = dotg_pkg::MAX_ROW_PIXELS_DEF,
   parameter int MAX_ROWS       = dotg_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // word_index[4:0], word_value[36:5], zero pad
   input  logic                          req_tuser,  // action
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [127:0]                  rsp_tdata,  // offset_x[63:0], offset_y[127:64]
   output logic                          rsp_tlast,  // last_of_frame
   // configuration
   input  logic                          csr_we,
   input  logic [dotg_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [dotg_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int XW  = $clog2(MAX_ROW_PIXELS);
   localparam int YW  = $clog2(MAX_ROWS);
   // compare widths: hold both the next position and the register value
   localparam int XCW = (XW + 1 > dotg_pkg::CFG_W) ? XW + 1 : dotg_pkg::CFG_W;
   localparam int YCW = (YW + 1 > dotg_pkg::CFG_W) ? YW + 1 : dotg_pkg::CFG_W;

   logic                        accept;
   logic                        is_pixel;
   logic                        is_load;

   logic [dotg_pkg::CFG_W-1:0]  width_ff, width_in;
   logic [dotg_pkg::CFG_W-1:0]  height_ff, height_in;
   logic [XW-1:0]               col_ff, col_in;
   logic [YW-1:0]               row_ff, row_in;

   logic [XCW-1:0]              width_lim, col_nxt, width_ext;
   logic [YCW-1:0]              height_lim, row_nxt, height_ext;
   logic                        row_end;
   logic                        frame_end;

   dotg_pkg::ctl_type           ctl;
   dotg_pkg::acc_type           offset_x, offset_y;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [127:0]                rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   // ---- handshake: output register drains or is empty ----
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pixel   = accept && (req_tuser == dotg_pkg::ACT_PIXEL);
   assign is_load    = accept && (req_tuser == dotg_pkg::ACT_LOAD);

   // ---- configuration ----
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            dotg_pkg::REG_WIDTH:  width_in  = csr_wdata;
            dotg_pkg::REG_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- effective frame size: zero means one, above max saturates ----
   assign width_ext  = XCW'(width_ff);
   assign height_ext = YCW'(height_ff);

   always_comb begin
      if (width_ext == '0) begin
         width_lim = XCW'(1);
      end else if (width_ext > XCW'(MAX_ROW_PIXELS)) begin
         width_lim = XCW'(MAX_ROW_PIXELS);
      end else begin
         width_lim = width_ext;
      end
      if (height_ext == '0) begin
         height_lim = YCW'(1);
      end else if (height_ext > YCW'(MAX_ROWS)) begin
         height_lim = YCW'(MAX_ROWS);
      end else begin
         height_lim = height_ext;
      end
   end

   // ---- raster position ----
   assign col_nxt   = XCW'(col_ff) + XCW'(1);
   assign row_nxt   = YCW'(row_ff) + YCW'(1);
   assign row_end   = col_nxt >= width_lim;
   assign frame_end = row_end && (row_nxt >= height_lim);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (is_load) begin
         col_in = '0;
         row_in = '0;
      end else if (is_pixel) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_nxt[YW-1:0];
         end else begin
            col_in = col_nxt[XW-1:0];
         end
      end
   end

   // ---- accumulator datapath ----
   always_comb begin
      ctl.load       = is_load;
      ctl.pixel      = is_pixel;
      ctl.first_col  = (col_ff == '0);
      ctl.restart    = is_load || (is_pixel && frame_end);
      ctl.word_index = req_tdata[4:0];
      ctl.word_value = req_tdata[36:5];
   end

   dotg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .offset_x (offset_x),
      .offset_y (offset_y)
   );

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (is_pixel) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {offset_y, offset_x};
         rsp_last_in  = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= dotg_pkg::WIDTH_RST;
         height_ff    <= dotg_pkg::HEIGHT_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // pending end-of-frame beat implies the raster has wrapped to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("end of frame pending but position not at origin");

   // every pixel beat yields a result beat next cycle
   a_pixel_result: assert property (@(posedge clock) disable iff (reset)
      is_pixel |=> rsp_valid_ff)
      else $error("pixel beat produced no result");

   // a calibration load yields no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      is_load |=> !rsp_valid_ff)
      else $error("load beat produced a result");
`endif

endmodule

>>> tb/testbench.sv
module testbench;

   // --------------------------------------------------------------------
   // Run limits
   // --------------------------------------------------------------------
   // Slowest legal run: roughly 550 beats, each stuck behind a sender gap
   // and a result stall, plus drains between phases; the limit below
   // leaves a wide margin over that.
   localparam int unsigned CYCLE_LIMIT  = 100000;
   localparam int unsigned RANDOM_BEATS = 280;
   localparam int unsigned IDX_W        = dotg_pkg::IDX_W;
   localparam int unsigned ACC_W        = dotg_pkg::ACC_W;
   localparam int unsigned CFG_W        = dotg_pkg::CFG_W;
   localparam int unsigned NUM_WORDS    = dotg_pkg::NUM_WORDS;
   localparam logic [IDX_W-1:0] NO_SUCH_WORD = 5'd31;  // above the last word

   // short names for the table below
   localparam logic LOAD  = dotg_pkg::ACT_LOAD;
   localparam logic PIXEL = dotg_pkg::ACT_PIXEL;
   localparam int   START = dotg_pkg::W_START;

   typedef struct packed {
      logic [ACC_W-1:0] x;
      logic [ACC_W-1:0] y;
      logic             frame_end;
   } offsets_type;

   // One row of the directed table. When typed is set, the offsets below
   // are what the block must produce; otherwise the predictor decides.
   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] idx;
      logic [31:0]      value;
      logic             typed;
      logic [ACC_W-1:0] ex;
      logic [ACC_W-1:0] ey;
      logic             el;
   } stim_row_type;

   localparam logic [ACC_W-1:0] PLUS_512  = 64'd512;
   localparam logic [ACC_W-1:0] MINUS_512 = 64'hFFFF_FFFF_FFFF_FE00;

   // --------------------------------------------------------------------
   // DUT hookup
   // --------------------------------------------------------------------
   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [39:0]                    req_tdata;   // word_index[4:0], word_value[36:5], zero pad
   logic                           req_tuser;   // action
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [127:0]                   rsp_tdata;   // offset_x[63:0], offset_y[127:64]
   logic                           rsp_tlast;   // last_of_frame
   logic                           csr_we;
   logic [dotg_pkg::CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]               csr_wdata;

   depth_offset_table_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // Predictor state: our own copy of the calibration and accumulators
   // --------------------------------------------------------------------
   logic [31:0]      cal_word [0:NUM_WORDS-1];
   logic [ACC_W-1:0] row_acc  [0:dotg_pkg::NUM_ROW-1];
   logic [ACC_W-1:0] col_acc  [0:dotg_pkg::NUM_COL-1];
   int unsigned      row_pos;
   int unsigned      col_pos;
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;

   offsets_type offset_queue [$];
   int unsigned errors;
   int unsigned cycles;
   int unsigned loads_done;
   int unsigned pixels_done;
   int unsigned frames_done;
   int unsigned settings_done;
   bit          calm;          // no idling on either side once set

   function automatic logic [ACC_W-1:0] widen(logic [31:0] w);
      return {{32{w[31]}}, w};
   endfunction

   function automatic logic [ACC_W-1:0] shr(logic [ACC_W-1:0] v, int unsigned n);
      return $signed(v) >>> n;
   endfunction

   // start values are scaled in 32-bit wrapping arithmetic, then widened
   function automatic logic [ACC_W-1:0] prescale(logic [31:0] w, int unsigned up,
                                                 int unsigned dn);
      logic [31:0] t;
      t = w << up;
      t = $signed(t) >>> dn;
      return widen(t);
   endfunction

   function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   // back to the first pixel, rows seeded from the start values
   task automatic reseed_rows();
      row_acc[dotg_pkg::RA_X] = prescale(cal_word[START], 13, 4);
      row_acc[dotg_pkg::RA_Y] = prescale(cal_word[START+1], 13, 4);
      for (int i = 0; i < 4; i++)
         row_acc[dotg_pkg::RA_XDX+i] = prescale(cal_word[START+2+i], 11, 3);
      for (int i = 0; i < 6; i++)
         row_acc[dotg_pkg::RA_XXX+i] = prescale(cal_word[START+6+i], 8, 0);
      row_pos = 0;
      col_pos = 0;
   endtask

   // Offsets for the next pixel in raster order. Updates are written in
   // an order where every term still reads the value from before the step.
   task automatic next_offsets(output offsets_type o);
      int unsigned w;
      int unsigned h;
      w = clamp_dim(width_reg, dotg_pkg::MAX_ROW_PIXELS_DEF);
      h = clamp_dim(height_reg, dotg_pkg::MAX_ROWS_DEF);
      if (col_pos == 0) begin
         row_acc[dotg_pkg::RA_XXX] += widen(cal_word[dotg_pkg::W_CX]);
         row_acc[dotg_pkg::RA_XDX] += shr(row_acc[dotg_pkg::RA_YXX], 8);
         row_acc[dotg_pkg::RA_YXX] += widen(cal_word[dotg_pkg::W_DX]);
         row_acc[dotg_pkg::RA_X]   += shr(row_acc[dotg_pkg::RA_YDX], 6);
         row_acc[dotg_pkg::RA_YDX] += shr(row_acc[dotg_pkg::RA_YYX], 8);
         row_acc[dotg_pkg::RA_YYX] += widen(cal_word[dotg_pkg::W_BX]);
         row_acc[dotg_pkg::RA_XXY] += widen(cal_word[dotg_pkg::W_CY]);
         row_acc[dotg_pkg::RA_XDY] += shr(row_acc[dotg_pkg::RA_YXY], 8);
         row_acc[dotg_pkg::RA_YXY] += widen(cal_word[dotg_pkg::W_DY]);
         row_acc[dotg_pkg::RA_Y]   += shr(row_acc[dotg_pkg::RA_YDY], 6);
         row_acc[dotg_pkg::RA_YDY] += shr(row_acc[dotg_pkg::RA_YYY], 8);
         row_acc[dotg_pkg::RA_YYY] += widen(cal_word[dotg_pkg::W_BY]);
         col_acc[0] = row_acc[dotg_pkg::RA_X];
         col_acc[1] = row_acc[dotg_pkg::RA_XDX];
         col_acc[2] = row_acc[dotg_pkg::RA_XXX];
         col_acc[3] = row_acc[dotg_pkg::RA_Y];
         col_acc[4] = row_acc[dotg_pkg::RA_XDY];
         col_acc[5] = row_acc[dotg_pkg::RA_XXY];
      end
      o.x = col_acc[0];
      o.y = col_acc[3];
      col_acc[0] += shr(col_acc[1], 6);
      col_acc[1] += shr(col_acc[2], 8);
      col_acc[2] += widen(cal_word[dotg_pkg::W_AX]);
      col_acc[3] += shr(col_acc[4], 6);
      col_acc[4] += shr(col_acc[5], 8);
      col_acc[5] += widen(cal_word[dotg_pkg::W_AY]);
      // width/height may have shrunk under a frame in progress: use >=
      o.frame_end = 1'b0;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) o.frame_end = 1'b1;
      end
      if (o.frame_end) reseed_rows();
   endtask

   // --------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------
   // Drive one beat, hold it until taken, then record what it should cause.
   task automatic push_beat(input logic act, input logic [IDX_W-1:0] idx,
                            input logic [31:0] val, input bit typed,
                            input offsets_type want);
      offsets_type o;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, val, idx};
      do @(posedge clock); while (!req_tready);
      if (act == LOAD) begin
         if (idx < NUM_WORDS) cal_word[idx] = val;
         reseed_rows();
         loads_done++;
      end else begin
         next_offsets(o);
         offset_queue.push_back(typed ? want : o);
         pixels_done++;
      end
   endtask

   // sender stops and waits for every outstanding offset pair
   task automatic drain_offsets();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (offset_queue.size() != 0);
   endtask

   // Both registers are written while idle. Loads leave nothing in the
   // queue, so the pipe is also left to settle before the writes.
   task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_offsets();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= dotg_pkg::REG_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= dotg_pkg::REG_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg  = w;
      height_reg = h;
      settings_done++;
   endtask

   task automatic run_pixels(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) push_beat(PIXEL, '0, '0, 1'b0, '0);
   endtask

   // mostly plain random words, now and then one of the extremes
   function automatic logic [31:0] cal_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Result side: random stall bursts, stops stalling once calm
   // --------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic report(input string what, input logic [ACC_W-1:0] got,
                         input logic [ACC_W-1:0] want);
      $display("MISMATCH @%0d: %s got %h expected %h", cycles, what, got, want);
      errors++;
   endtask

   // Checker and watchdog. Pops happen here, pushes in the sender; a beat
   // accepted at an edge cannot show its result before the next edge.
   always @(posedge clock) begin
      offsets_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, offset_queue.size());
         $display("status: fail");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (offset_queue.size() == 0) begin
            report("unexpected result beat, x", rsp_tdata[63:0], '0);
         end else begin
            want = offset_queue.pop_front();
            if (rsp_tdata[63:0] !== want.x)   report("offset_x", rsp_tdata[63:0], want.x);
            if (rsp_tdata[127:64] !== want.y) report("offset_y", rsp_tdata[127:64], want.y);
            if (rsp_tlast !== want.frame_end)
               report("last_of_frame", 64'(rsp_tlast), 64'(want.frame_end));
            if (rsp_tlast === 1'b1) frames_done++;
         end
      end
   end

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   stim_row_type directed [0:24];

   initial begin
      int unsigned random_beats;
      int unsigned n;
      int unsigned frame_beats;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      offsets_type want;

      cycles = 0;
      errors = 0;
      loads_done = 0;
      pixels_done = 0;
      frames_done = 0;
      settings_done = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = PIXEL;
      csr_we = 1'b0;
      csr_index = dotg_pkg::REG_WIDTH;
      csr_wdata = '0;

      // predictor reset: all words zero, default 640 x 480
      foreach (cal_word[i]) cal_word[i] = '0;
      foreach (col_acc[i]) col_acc[i] = '0;
      width_reg  = dotg_pkg::WIDTH_RST;
      height_reg = dotg_pkg::HEIGHT_RST;
      reseed_rows();

      // Directed: pixel straight out of reset, X/Y start seeds (+1, -1 and
      // one that overflows the pre-shift), a load past the last word that
      // only restarts, then every coefficient class at its extremes.
      directed = '{
         '{PIXEL, 5'd0,                 32'd0,         1'b1, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START),            32'd1,         1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b1, PLUS_512, 64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b1, PLUS_512, 64'd0,     1'b0},
         '{LOAD,  5'(START+1),          32'hFFFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b1, PLUS_512, MINUS_512, 1'b0},
         '{LOAD,  NO_SUCH_WORD,         32'h1234_5678, 1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b1, PLUS_512, MINUS_512, 1'b0},
         '{LOAD,  5'(START),            32'h8000_0000, 1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b1, 64'd0,    MINUS_512, 1'b0},
         '{LOAD,  5'(dotg_pkg::W_AX),   32'h7FFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(dotg_pkg::W_CX),   32'h8000_0000, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(dotg_pkg::W_AY),   32'h8000_0000, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(dotg_pkg::W_BY),   32'h7FFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(dotg_pkg::W_DX),   32'hFFFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START+2),          32'h7FFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START+6),          32'h7FFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START+11),         32'h8000_0000, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START+12),         32'h5555_5555, 1'b0, 64'd0,    64'd0,     1'b0},
         '{LOAD,  5'(START+13),         32'hFFFF_FFFF, 1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b0, 64'd0,    64'd0,     1'b0},
         '{PIXEL, 5'd0,                 32'd0,         1'b0, 64'd0,    64'd0,     1'b0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         want = '{directed[i].ex, directed[i].ey, directed[i].el};
         push_beat(directed[i].action, directed[i].idx, directed[i].value,
                   directed[i].typed, want);
      end

      // zero size reads as one: every pixel closes a frame
      set_size('0, '0);
      run_pixels(5);
      // over-range width and height: short runs inside the saturated frame
      set_size(11'd2047, 11'd1);
      run_pixels(8);
      set_size(11'd1, 11'h7FF);
      run_pixels(8);
      // shrink under a frame in progress: column already past the new width
      set_size(11'd1024, 11'd1);
      run_pixels(37);
      set_size(11'd3, 11'd2);
      run_pixels(12);

      // Random phases: a size setting, often a full calibration sweep, then
      // pixels for a few frames with the odd stray load and a full drain.
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = CFG_W'($urandom_range(7, 2047));
            default: w = CFG_W'($urandom_range(1, 6));
         endcase
         h = ($urandom_range(0, 6) == 0) ? '0 : CFG_W'($urandom_range(1, 5));
         set_size(w, h);
         if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < NUM_WORDS; i++) push_beat(LOAD, IDX_W'(i), cal_value(),
                                                          1'b0, '0);
            random_beats += NUM_WORDS;
         end
         frame_beats = clamp_dim(w, dotg_pkg::MAX_ROW_PIXELS_DEF) *
                       clamp_dim(h, dotg_pkg::MAX_ROWS_DEF);
         n = frame_beats * $urandom_range(1, 3) + $urandom_range(0, 3);
         if (n > 60) n = 60;
         for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 99)) inside
               [0:4]:   push_beat(LOAD, IDX_W'($urandom_range(0, 31)), cal_value(),
                                  1'b0, '0);
               5:       drain_offsets();
               default: push_beat(PIXEL, '0, '0, 1'b0, '0);
            endcase
         end
         random_beats += n;
      end

      // closing stretch at full rate: fresh calibration, several small frames
      calm = 1'b1;
      set_size(11'd4, 11'd3);
      for (int i = 0; i < NUM_WORDS; i++) push_beat(LOAD, IDX_W'(i), cal_value(), 1'b0, '0);
      run_pixels(40);

      drain_offsets();
      repeat (10) @(posedge clock);

      $display("run: %0d pixel beats, %0d calibration loads, %0d size settings",
               pixels_done, loads_done, settings_done);
      $display("run: %0d frame ends seen, %0d mismatches, %0d cycles",
               frames_done, errors, cycles);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/dotg_pkg.sv
hdl/dotg_datapath.sv
hdl/depth_offset_table_generator.sv
tb/testbench.sv
